// ===== design/sme_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute package
// Field widths, instruction and status codes, and the command group that
// the controller sends to the datapath.
// ----------------------------------------------------------------------------
package sme_pkg;

    // Widths of the item fields on the ports.
    localparam int OP_W        = 2;
    localparam int VAL_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 9;
    localparam int PC_W        = 16;

    // Instruction codes.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_ADD  = 2'd2,
        OP_SUB  = 2'd3
    } t_op;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_UNDER = 2'd2,
        ST_OVER  = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

endpackage

// ===== design/stack_machine_execute_top.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute unit
// Executes push, pop, add and subtract instructions on a stack held as a
// top-entry register in front of a RAM, and reports one result per item.
// ----------------------------------------------------------------------------
//  Channel   Valid     Stall     Payload
//  input     i_valid   o_stall   i_op, i_push_value
//  result    o_valid   i_stall   o_status, o_top_value, o_entry_count,
//                                o_instr_counter
//
//  Each item is taken in the idle state, while the registered RAM read of the
//  second entry completes, and executed in the execute state. An item is
//  taken even while a result is stalled; it executes at the edge that takes
//  that result, and the input stalls until then.
//  Reset empties the stack and clears the program counter; the RAM contents
//  are not cleared, and an unwritten entry that is read never reaches a result.
// ----------------------------------------------------------------------------
module stack_machine_execute_top #(
    parameter int STACK_DEPTH = 256,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [sme_pkg::OP_W-1:0]             i_op,
    input  logic signed [sme_pkg::VAL_W-1:0]     i_push_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [sme_pkg::STATUS_W-1:0]         o_status,
    output logic signed [sme_pkg::VAL_W-1:0]     o_top_value,
    output logic [sme_pkg::COUNT_OUT_W-1:0]      o_entry_count,
    output logic [sme_pkg::PC_W-1:0]             o_instr_counter
);

    import sme_pkg::*;

    t_dp_cmd dp_cmd;

    // Controller.
    sme_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (dp_cmd)
    );

    // Datapath.
    sme_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .i_op            (i_op),
        .i_push_value    (i_push_value),
        .o_status        (o_status),
        .o_top_value     (o_top_value),
        .o_entry_count   (o_entry_count),
        .o_instr_counter (o_instr_counter)
    );

`ifndef SYNTH
    // After an item is accepted, a result is on offer: its own or a stalled earlier one.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> ##1 o_valid)
        else $error("result did not follow an accepted item");

    // A stalled result holds its value until it is taken.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status) && $stable(o_top_value)
            && $stable(o_entry_count) && $stable(o_instr_counter)))
        else $error("stalled result changed");

    // Underflow only happens on an empty stack, which shows zero.
    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_UNDER)) |-> ((o_entry_count == '0) && (o_top_value == '0)))
        else $error("underflow reported on a stack that is not empty");

    // Overflow only happens on a full stack.
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_OVER)) |-> (o_entry_count == COUNT_OUT_W'(STACK_DEPTH)))
        else $error("overflow reported on a stack that is not full");
`endif

endmodule

// ===== design/sme_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/sme_datapath.sv =====
// ----------------------------------------------------------------------------
// Stack machine datapath
// Holds the top entry in a register and the entries below it in a RAM,
// along with the entry count, the program counter and the result registers.
// ----------------------------------------------------------------------------
module sme_datapath #(
    parameter int STACK_DEPTH = 256,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  sme_pkg::t_dp_cmd                       i_cmd,
    input  logic [sme_pkg::OP_W-1:0]               i_op,
    input  logic signed [sme_pkg::VAL_W-1:0]       i_push_value,
    output logic [sme_pkg::STATUS_W-1:0]           o_status,
    output logic signed [sme_pkg::VAL_W-1:0]       o_top_value,
    output logic [sme_pkg::COUNT_OUT_W-1:0]        o_entry_count,
    output logic [sme_pkg::PC_W-1:0]               o_instr_counter
);

    import sme_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);

    // Captured instruction.
    t_op                   r_op;
    logic [DATA_WIDTH-1:0] r_val;

    // Stack state.
    logic [DATA_WIDTH-1:0] r_tos;
    logic [DATA_WIDTH-1:0] n_tos;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [PC_W-1:0]       r_pc;
    logic [PC_W-1:0]       n_pc;
    t_status               n_status;

    // Result registers.
    t_status               r_status;
    logic [VAL_W-1:0]      r_top;
    logic [COUNT_OUT_W-1:0] r_entry;

    // RAM access.
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    // Widened copies used to take the low bits of the result fields.
    logic [DATA_WIDTH+VAL_W-1:0]     top_ext;
    logic [CNT_W+COUNT_OUT_W-1:0]    cnt_ext;

    // The RAM holds every entry below the top one; the second entry is read
    // while the datapath waits for an item.
    assign rd_addr = ADDR_W'(r_count - CNT_W'(2));
    assign wr_addr = ADDR_W'(r_count - CNT_W'(1));

    sme_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_tos),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Instruction decode and next stack state.
    always_comb begin
        n_status = ST_OK;
        n_count  = r_count;
        n_tos    = r_tos;
        wr_en    = 1'b0;
        unique case (r_op) inside
            OP_PUSH: begin
                if (r_count == DEPTH_C) begin
                    n_status = ST_OVER;
                end else begin
                    n_tos   = r_val;
                    n_count = r_count + CNT_W'(1);
                    // The old top entry moves down into the RAM.
                    wr_en   = i_cmd.execute && (r_count != '0);
                end
            end
            OP_POP: begin
                if (r_count == '0) begin
                    n_status = ST_UNDER;
                end else begin
                    n_tos   = rd_data;
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_ADD, OP_SUB: begin
                if (r_count < CNT_W'(2)) begin
                    n_status = ST_SHORT;
                end else begin
                    n_tos   = (r_op == OP_ADD) ? (rd_data + r_tos) : (rd_data - r_tos);
                    n_count = r_count - CNT_W'(1);
                end
            end
        endcase
        n_pc = (n_status == ST_OK) ? (r_pc + PC_W'(1)) : r_pc;
    end

    // Result fields are the low bits of the new state; an empty stack shows zero.
    assign top_ext = {{VAL_W{1'b0}}, n_tos};
    assign cnt_ext = {{COUNT_OUT_W{1'b0}}, n_count};

    // Control state: entry count and program counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pc    <= '0;
        end else if (i_cmd.execute) begin
            r_count <= n_count;
            r_pc    <= n_pc;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= t_op'(i_op);
            r_val <= DATA_WIDTH'(i_push_value);
        end
        if (i_cmd.execute) begin
            r_tos    <= n_tos;
            r_status <= n_status;
            r_top    <= (n_count == '0) ? '0 : top_ext[VAL_W-1:0];
            r_entry  <= cnt_ext[COUNT_OUT_W-1:0];
        end
    end

    assign o_status        = r_status;
    assign o_top_value     = $signed(r_top);
    assign o_entry_count   = r_entry;
    assign o_instr_counter = r_pc;

endmodule

// ===== design/sme_ctrl.sv =====
// ----------------------------------------------------------------------------
// Stack machine controller
// Takes one item at a time, sequences its execution in the datapath and
// holds the result valid flag until the result is taken.
// ----------------------------------------------------------------------------
module sme_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    output sme_pkg::t_dp_cmd o_cmd
);

    import sme_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   can_take;
    logic   res_free;

    // An item is taken whenever the controller is idle. It executes once the
    // result register is free, either empty or being taken at that edge.
    assign can_take = i_rst_n && (r_state == S_IDLE);
    assign res_free = !r_out_valid || !i_stall;

    assign o_stall       = !can_take;
    assign o_valid       = r_out_valid;
    assign o_cmd.capture = can_take && i_valid;
    assign o_cmd.execute = (r_state == S_EXEC) && res_free;

    // State and result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.capture) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (o_cmd.execute) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
            if (o_cmd.execute) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== dv/stack_exec_checker.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute checker
// Watches the instruction and result channels of the execute unit. It keeps
// its own copy of the stack and the program counter, predicts one result per
// accepted instruction item and compares every accepted result item, field by
// field, with the oldest prediction.
// ----------------------------------------------------------------------------
module stack_exec_checker #(
    parameter int STACK_DEPTH = 256,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic                                 o_stall,
    input  logic [sme_pkg::OP_W-1:0]             i_op,
    input  logic signed [sme_pkg::VAL_W-1:0]     i_push_value,
    input  logic                                 o_valid,
    input  logic                                 i_stall,
    input  logic [sme_pkg::STATUS_W-1:0]         o_status,
    input  logic signed [sme_pkg::VAL_W-1:0]     o_top_value,
    input  logic [sme_pkg::COUNT_OUT_W-1:0]      o_entry_count,
    input  logic [sme_pkg::PC_W-1:0]             o_instr_counter,
    output int                                   o_fail_count,
    output int                                   o_outstanding
);
    import sme_pkg::*;

    // One predicted result item.
    typedef struct {
        t_status                    status;
        logic signed [VAL_W-1:0]    top_value;
        logic [COUNT_OUT_W-1:0]     entry_count;
        logic [PC_W-1:0]            instr_counter;
    } t_exec_result;

    // Shadow copy of the machine state.
    logic [DATA_WIDTH-1:0] stack_mem [STACK_DEPTH];
    int                    depth;
    logic [PC_W-1:0]       pc;

    t_exec_result predicted_results [$];
    int           mismatches = 0;
    int           backlog    = 0;

    assign o_fail_count  = mismatches;
    assign o_outstanding = backlog;

    // Executes one instruction on the shadow state and returns what the unit
    // should report afterwards. A failing instruction leaves the state alone.
    function automatic t_exec_result execute_instr(t_op op, logic signed [VAL_W-1:0] operand);
        t_exec_result          res;
        logic [DATA_WIDTH-1:0] top_word;
        logic [DATA_WIDTH-1:0] next_word;
        res.status = ST_OK;
        case (op)
            OP_PUSH: begin
                if (depth >= STACK_DEPTH) begin
                    res.status = ST_OVER;
                end else begin
                    stack_mem[depth] = DATA_WIDTH'(operand);
                    depth++;
                end
            end
            OP_POP: begin
                if (depth == 0) begin
                    res.status = ST_UNDER;
                end else begin
                    depth--;
                end
            end
            default: begin
                if (depth < 2) begin
                    res.status = ST_SHORT;
                end else begin
                    // Subtract takes the second entry minus the top one.
                    top_word  = stack_mem[depth-1];
                    next_word = stack_mem[depth-2];
                    stack_mem[depth-2] = (op == OP_ADD) ? next_word + top_word
                                                        : next_word - top_word;
                    depth--;
                end
            end
        endcase
        if (res.status == ST_OK) begin
            pc++;
        end
        res.top_value     = (depth > 0) ? VAL_W'(stack_mem[depth-1]) : '0;
        res.entry_count   = COUNT_OUT_W'(depth);
        res.instr_counter = pc;
        return res;
    endfunction

    // Results are compared before the instruction of the same edge is
    // predicted, since an item taken at this edge cannot have a result yet.
    always @(posedge i_clk) begin
        t_exec_result oldest;
        if (!i_rst_n) begin
            depth = 0;
            pc    = '0;
            predicted_results.delete();
        end else begin
            if (o_valid === 1'b1 && i_stall === 1'b0) begin
                if (predicted_results.size() == 0) begin
                    $error("result item with no instruction item outstanding");
                    mismatches++;
                end else begin
                    oldest = predicted_results.pop_front();
                    if (o_status !== oldest.status) begin
                        $error("status: expected %0d, got %0d", oldest.status, o_status);
                        mismatches++;
                    end
                    if (o_top_value !== oldest.top_value) begin
                        $error("top_value: expected %0d, got %0d",
                               oldest.top_value, o_top_value);
                        mismatches++;
                    end
                    if (o_entry_count !== oldest.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               oldest.entry_count, o_entry_count);
                        mismatches++;
                    end
                    if (o_instr_counter !== oldest.instr_counter) begin
                        $error("instr_counter: expected %0d, got %0d",
                               oldest.instr_counter, o_instr_counter);
                        mismatches++;
                    end
                end
            end
            if (i_valid === 1'b1 && o_stall === 1'b0) begin
                predicted_results.push_back(execute_instr(t_op'(i_op), i_push_value));
            end
        end
        backlog = predicted_results.size();
    end

endmodule

// ===== dv/stack_machine_execute_top_tb.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute testbench
// Drives instruction items into the execute unit: a directed pass over the
// operand extremes, underflow and short stacks, then random runs that fill
// the stack past full, drain it past empty and mix all instructions, and
// finally a run without gaps on either channel. Both channels idle at random.
// The checker beside the unit predicts and compares every result item.
// ----------------------------------------------------------------------------
module stack_machine_execute_top_tb;
    import sme_pkg::*;

    localparam int STACK_DEPTH    = 256;
    localparam int DATA_WIDTH     = 32;
    localparam int ITEM_TARGET    = 850;
    localparam int GAPLESS_GROUPS = 25;
    localparam int CYCLE_LIMIT    = 1000000;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       i_valid      = 1'b0;
    logic [OP_W-1:0]            i_op         = '0;
    logic signed [VAL_W-1:0]    i_push_value = '0;
    logic                       i_stall      = 1'b0;
    logic                       o_stall;
    logic                       o_valid;
    logic [STATUS_W-1:0]        o_status;
    logic signed [VAL_W-1:0]    o_top_value;
    logic [COUNT_OUT_W-1:0]     o_entry_count;
    logic [PC_W-1:0]            o_instr_counter;

    int fail_count;
    int outstanding;
    int items_sent  = 0;
    int cycle_count = 0;
    bit stall_on    = 1'b0;
    int stall_hold  = 0;

    stack_machine_execute_top #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_push_value    (i_push_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_top_value     (o_top_value),
        .o_entry_count   (o_entry_count),
        .o_instr_counter (o_instr_counter)
    );

    stack_exec_checker #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_push_value    (i_push_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_top_value     (o_top_value),
        .o_entry_count   (o_entry_count),
        .o_instr_counter (o_instr_counter),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding)
    );

    // Clock with a period of two time units.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Operand with extra weight on the extremes of the signed range.
    function automatic logic signed [VAL_W-1:0] pick_operand();
        case ($urandom_range(0, 11))
            0:       return {1'b0, {(VAL_W-1){1'b1}}};
            1:       return {1'b1, {(VAL_W-1){1'b0}}};
            2:       return '1;
            3:       return '0;
            4:       return 1;
            default: return $urandom;
        endcase
    endfunction

    // Sends one instruction item and returns at the edge that takes it.
    task automatic issue(t_op op, logic signed [VAL_W-1:0] operand);
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_op         <= op;
        i_push_value <= operand;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        items_sent++;
    endtask

    // Holds the instruction channel idle with junk on the payload.
    task automatic hold_off(int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid      <= 1'b0;
            i_op         <= OP_W'($urandom);
            i_push_value <= $urandom;
        end
    endtask

    // A run of random instructions where push_pct sets the share of pushes.
    // The run picks its own idling on both channels.
    task automatic run_segment(int n, int push_pct);
        bit  idle_on;
        t_op op;
        idle_on  = ($urandom_range(0, 4) != 0);
        stall_on = ($urandom_range(0, 4) != 0);
        repeat (n) begin
            if (idle_on) begin
                hold_off(pause_len());
            end
            if ($urandom_range(0, 99) < push_pct) begin
                op = OP_PUSH;
            end else begin
                op = t_op'($urandom_range(1, 3));
            end
            issue(op, pick_operand());
        end
    endtask

    // Result back-pressure: alternating open and stalled stretches.
    always @(negedge i_clk) begin
        if (!stall_on) begin
            i_stall    <= 1'b0;
            stall_hold <= 0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else if (i_stall) begin
            i_stall    <= 1'b0;
            stall_hold <= $urandom_range(0, 5);
        end else begin
            i_stall    <= 1'b1;
            stall_hold <= pause_len();
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        int  sel;
        t_op mix_op;
        repeat (10) @(posedge i_clk);
        stall_on = 1'b1;
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Faults on an empty stack and on a stack of one.
        issue(OP_POP, '0);
        issue(OP_ADD, '1);
        issue(OP_SUB, {1'b0, {(VAL_W-1){1'b1}}});
        issue(OP_PUSH, {1'b0, {(VAL_W-1){1'b1}}});
        issue(OP_ADD, '0);
        issue(OP_SUB, '0);
        // Add wraps past the largest value, subtract wraps back below the smallest.
        issue(OP_PUSH, 1);
        issue(OP_ADD, '0);
        issue(OP_PUSH, 1);
        issue(OP_SUB, '0);
        issue(OP_PUSH, {1'b1, {(VAL_W-1){1'b0}}});
        issue(OP_PUSH, '1);
        issue(OP_SUB, '0);
        issue(OP_ADD, '0);
        issue(OP_PUSH, '0);
        issue(OP_PUSH, '1);
        issue(OP_ADD, '0);
        // Pop down to empty, then once more for an underflow.
        issue(OP_POP, '1);
        issue(OP_POP, '0);
        issue(OP_POP, '0);
        issue(OP_PUSH, 32'sh5555_5555);
        issue(OP_PUSH, 32'shAAAA_AAAA);
        issue(OP_SUB, '0);
        issue(OP_POP, '0);

        // Fill past full, mix, drain past empty, then random runs.
        run_segment($urandom_range(256, 264), 100);
        repeat (3) run_segment($urandom_range(10, 50), 50);
        run_segment($urandom_range(256, 264), 0);
        while (items_sent < ITEM_TARGET) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                run_segment($urandom_range(256, 264), 100);
            end else if (sel == 1) begin
                run_segment($urandom_range(256, 264), 0);
            end else begin
                run_segment($urandom_range(10, 50), 10 + 20 * $urandom_range(0, 4));
            end
        end

        // Back-to-back groups with no gaps on either channel.
        stall_on = 1'b0;
        repeat (GAPLESS_GROUPS) begin
            if ($urandom_range(0, 1) != 0) begin
                mix_op = OP_ADD;
            end else begin
                mix_op = OP_SUB;
            end
            issue(OP_PUSH, pick_operand());
            issue(OP_PUSH, pick_operand());
            issue(mix_op, $urandom);
            issue(OP_POP, $urandom);
        end
        hold_off(1);

        // Drain the remaining results, then report the verdict.
        do @(negedge i_clk); while (outstanding != 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
